// File: src/rlf_pkg.sv
// Shared constants, types and elaboration-time colour table arithmetic for the LED frame word core.
package rlf_pkg;

	localparam int LIT_LEDS    = 144;
	localparam int FRAME_WORDS = 256;
	localparam int LIT_LIMIT   = (LIT_LEDS < FRAME_WORDS) ? LIT_LEDS : FRAME_WORDS;

	localparam int SLOT_W  = 8;
	localparam int STEP_W  = 14;
	localparam int POS_W   = 15;
	localparam int WORD_W  = 32;
	localparam int COL_W   = 8;
	localparam int ROM_AW  = 9;
	localparam int ROM_DEPTH = 512;
	localparam int INTEN_W = 12;
	localparam int CUR_W   = 5;
	localparam int PHASE_W = 24;

	localparam int INTEN_STEP = 178;
	localparam int INTEN_DIV  = 4095;
	localparam int PHASE_MOD  = 24;

	localparam logic [2:0] WORD_MARK = 3'b111;

	localparam int FX_FB = 56;
	localparam logic [63:0] ONE_FX     = 64'd1 << FX_FB;
	localparam logic [63:0] PI_FX      = 64'h0324_3F6A_8885_A309;
	localparam logic [63:0] PIF_MANT   = 64'h0000_0000_00C9_0FDB;
	localparam logic [63:0] THIRD_MANT = 64'h0000_0000_0086_0A92;
	localparam int SIN_TERMS = 14;

	typedef logic [COL_W-1:0]   colour_t;
	typedef logic [INTEN_W-1:0] inten_t;
	typedef logic [PHASE_MOD-1:0][INTEN_W-1:0] inten_lut_t;

	function automatic inten_lut_t build_inten_lut();
		inten_lut_t lut;
		int x;
		for (int m = 0; m < PHASE_MOD; m++) begin
			x = m * INTEN_STEP;
			lut[m] = INTEN_W'((x * x) / INTEN_DIV);
		end
		return lut;
	endfunction

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
		al = {32'd0, a[31:0]};
		ah = a >> 32;
		bl = {32'd0, b[31:0]};
		bh = b >> 32;
		ll = al * bl;
		lh = al * bh;
		hl = ah * bl;
		hh = ah * bh;
		mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
		lo = (mid << 32) | {32'd0, ll[31:0]};
		hi = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
		return (hi << (64 - FX_FB)) | (lo >> FX_FB);
	endfunction

	function automatic logic [63:0] round24(input logic [63:0] v);
		int top;
		int sh;
		logic [63:0] q, rem, half;
		top = 0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) top = i;
		end
		if (v == 64'd0 || top <= 23) return v;
		sh = top - 23;
		q = v >> sh;
		rem = v & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0])) q = q + 64'd1;
		return q << sh;
	endfunction

	// Bit 64 of the result carries the sign, the rest the magnitude.
	function automatic logic [64:0] fx_sin(input logic [63:0] x);
		logic [63:0] xr, sum, term, x2, prod;
		logic neg, sub, done;
		xr = x;
		neg = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (xr >= (PI_FX << 1)) xr = xr - (PI_FX << 1);
		end
		if (xr >= PI_FX) begin
			neg = 1'b1;
			xr = xr - PI_FX;
		end
		if (xr > (PI_FX >> 1)) xr = PI_FX - xr;
		sum = xr;
		term = xr;
		x2 = fx_mul(xr, xr);
		sub = 1'b1;
		done = 1'b0;
		for (int j = 0; j < SIN_TERMS; j++) begin
			if (!done) begin
				prod = fx_mul(term, x2);
				case (j)
					0: term = prod / 64'd6;
					1: term = prod / 64'd20;
					2: term = prod / 64'd42;
					3: term = prod / 64'd72;
					4: term = prod / 64'd110;
					5: term = prod / 64'd156;
					6: term = prod / 64'd210;
					7: term = prod / 64'd272;
					8: term = prod / 64'd342;
					9: term = prod / 64'd420;
					10: term = prod / 64'd506;
					11: term = prod / 64'd600;
					12: term = prod / 64'd702;
					13: term = prod / 64'd812;
					default: term = 64'd0;
				endcase
				if (term == 64'd0) begin
					done = 1'b1;
				end else begin
					sum = sub ? sum - term : sum + term;
					sub = !sub;
				end
			end
		end
		return {neg, sum};
	endfunction

	function automatic colour_t colour_entry(input logic [63:0] k, input logic [63:0] phase);
		logic [63:0] ang, s, sum, scaled;
		logic [64:0] sv;
		ang = round24(k * PIF_MANT);
		if (phase != 64'd0) ang = round24(ang + phase);
		sv = fx_sin(ang << (FX_FB - 30));
		s = round24(sv[63:0]);
		if (s > ONE_FX) s = ONE_FX;
		sum = round24(sv[64] ? ONE_FX - s : ONE_FX + s);
		scaled = round24(sum * 64'd127) >> FX_FB;
		return scaled[COL_W-1:0];
	endfunction

endpackage

// File: src/rlf_colour_rom.sv
// Three 512-entry sine colour tables with a registered read port.
module rlf_colour_rom
	import rlf_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [ROM_AW-1:0] addr,
	output colour_t           red,
	output colour_t           green,
	output colour_t           blue
);

	colour_t red_rom   [ROM_DEPTH];
	colour_t green_rom [ROM_DEPTH];
	colour_t blue_rom  [ROM_DEPTH];

	for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_entry
		localparam colour_t RED_K   = colour_entry(64'(k), 64'd0);
		localparam colour_t GREEN_K = colour_entry(64'(k), THIRD_MANT << 8);
		localparam colour_t BLUE_K  = colour_entry(64'(k), THIRD_MANT << 9);
		assign red_rom[k]   = RED_K;
		assign green_rom[k] = GREEN_K;
		assign blue_rom[k]  = BLUE_K;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red   <= red_rom[addr];
			green <= green_rom[addr];
			blue  <= blue_rom[addr];
		end
	end

endmodule

// File: src/rainbow_led_frame_word_core.sv
// Top level of the rainbow LED frame word generator: four-stage pipeline.
// An accepted item is registered in stage 1, then moves through stages 2 and 3 to the frame word register of stage 4.
// Throughput is one item per cycle; each stage holds one item and refills as soon
// as the stage after it moves on, so input stalls only when all four stages are full
// and the output word is not taken.
// The asynchronous reset clears all stage valid flags; the data registers are not reset.
module rainbow_led_frame_word_core
	import rlf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              slot_valid,
	output logic              slot_ready,
	input  logic [SLOT_W-1:0] led_slot,
	input  logic [STEP_W-1:0] time_step,
	output logic              word_valid,
	input  logic              word_ready,
	output logic [WORD_W-1:0] frame_word
);

	localparam inten_lut_t INTEN_LUT = build_inten_lut();

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic             lit_s1, lit_s2, lit_s3;
	logic [POS_W-1:0] p_s1;
	logic [4:0]       m_s2;
	colour_t          red_s2, green_s2, blue_s2;
	colour_t          red_s3, green_s3, blue_s3;
	logic [CUR_W-1:0] cur_s3;
	logic [7:0]       scale_s3;
	logic [WORD_W-1:0] frame_word_s4;

	logic [4:0]       digit_sum;
	logic [2:0]       fold;
	logic [1:0]       rem3;
	inten_t           inten;
	logic [CUR_W-1:0] cur_raw;
	logic [15:0]      red_prod, green_prod, blue_prod;

	assign rdy4 = !v_s4 || word_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign slot_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= slot_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			lit_s1 <= {1'b0, led_slot} < 9'(LIT_LIMIT);
			p_s1   <= POS_W'(led_slot) + POS_W'(time_step);
		end
	end

	// The position modulo 24 is eight times the eighth of it modulo 3, plus its low bits.
	always_comb begin
		digit_sum = 5'(p_s1[4:3]) + 5'(p_s1[6:5]) + 5'(p_s1[8:7])
			+ 5'(p_s1[10:9]) + 5'(p_s1[12:11]) + 5'(p_s1[14:13]);
		fold = 3'(digit_sum[4:2]) + 3'(digit_sum[1:0]);
		if (fold >= 3'd6) begin
			rem3 = 2'(fold - 3'd6);
		end else if (fold >= 3'd3) begin
			rem3 = 2'(fold - 3'd3);
		end else begin
			rem3 = fold[1:0];
		end
	end

	rlf_colour_rom u_colour_rom (
		.clk   (clk),
		.en    (rdy2),
		.addr  (p_s1[ROM_AW-1:0]),
		.red   (red_s2),
		.green (green_s2),
		.blue  (blue_s2)
	);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			lit_s2 <= lit_s1;
			m_s2   <= {rem3, p_s1[2:0]};
		end
	end

	assign inten   = INTEN_LUT[m_s2];
	assign cur_raw = inten[INTEN_W-1:7];

	always_ff @(posedge clk) begin
		if (rdy3) begin
			lit_s3   <= lit_s2;
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
			cur_s3   <= (cur_raw == '0) ? CUR_W'(1) : cur_raw;
			scale_s3 <= {cur_raw != '0, inten[6:0]};
		end
	end

	assign red_prod   = 16'(scale_s3) * 16'(red_s3);
	assign green_prod = 16'(scale_s3) * 16'(green_s3);
	assign blue_prod  = 16'(scale_s3) * 16'(blue_s3);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			if (lit_s3) begin
				frame_word_s4 <= {red_prod[15:8], green_prod[15:8], blue_prod[15:8],
					WORD_MARK, cur_s3};
			end else begin
				frame_word_s4 <= '0;
			end
		end
	end

	assign word_valid = v_s4;
	assign frame_word = frame_word_s4;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the rainbow LED frame word core, with its own colour table predictor.
module tb_top
	import rlf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_COUNT  = 1150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [STEP_W-1:0] step;
		bit                drain_first;
		bit                steady;
	} slot_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              slot_valid = 1'b0;
	logic              slot_ready;
	logic [SLOT_W-1:0] led_slot = '0;
	logic [STEP_W-1:0] time_step = '0;
	logic              word_valid;
	logic              word_ready = 1'b0;
	logic [WORD_W-1:0] frame_word;

	colour_t red_rom [ROM_DEPTH];
	colour_t green_rom [ROM_DEPTH];
	colour_t blue_rom [ROM_DEPTH];

	slot_item_t        slot_items [$];
	logic [WORD_W-1:0] expected_words [$];
	logic [WORD_W-1:0] wanted_word;
	slot_item_t        next_item;
	logic              in_fire = 1'b0;
	bit                out_steady = 1'b0;
	int                in_gap = 0;
	int                out_gap = 0;
	int                cycle_count = 0;
	int                mismatch_count = 0;

	rainbow_led_frame_word_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_valid (slot_valid),
		.slot_ready (slot_ready),
		.led_slot   (led_slot),
		.time_step  (time_step),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.frame_word (frame_word)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [63:0] fixed_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] wide;
		wide = {64'd0, a} * {64'd0, b};
		return wide[FX_FB+63:FX_FB];
	endfunction

	function automatic logic [63:0] round_to_single(input logic [63:0] v);
		int          top;
		int          sh;
		logic [63:0] q, rem, half;
		top = -1;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) top = i;
		end
		if (top <= 23) return v;
		sh = top - 23;
		q = v >> sh;
		rem = v & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0])) q = q + 64'd1;
		return q << sh;
	endfunction

	// The top bit of the result is the sign of the sine, the rest its magnitude.
	function automatic logic [64:0] fixed_sine(input logic [63:0] x);
		logic [63:0] a, sum, term, sq, n;
		logic        neg, sub, going;
		a = x;
		neg = 1'b0;
		while (a >= (PI_FX << 1)) a = a - (PI_FX << 1);
		if (a >= PI_FX) begin
			neg = 1'b1;
			a = a - PI_FX;
		end
		if (a > (PI_FX >> 1)) a = PI_FX - a;
		sum = a;
		term = a;
		sq = fixed_product(a, a);
		n = 64'd1;
		sub = 1'b1;
		going = 1'b1;
		while (going) begin
			term = fixed_product(term, sq) / ((n + 64'd1) * (n + 64'd2));
			n = n + 64'd2;
			if (term == 64'd0) begin
				going = 1'b0;
			end else begin
				sum = sub ? sum - term : sum + term;
				sub = !sub;
			end
		end
		return {neg, sum};
	endfunction

	function automatic colour_t sine_colour(input logic [63:0] k, input logic [63:0] phase);
		logic [63:0] ang, s, level, scaled;
		logic [64:0] signed_sine;
		ang = round_to_single(k * PIF_MANT);
		if (phase != 64'd0) ang = round_to_single(ang + phase);
		signed_sine = fixed_sine(ang << (FX_FB - 30));
		s = round_to_single(signed_sine[63:0]);
		if (s > ONE_FX) s = ONE_FX;
		level = round_to_single(signed_sine[64] ? ONE_FX - s : ONE_FX + s);
		scaled = round_to_single(level * 64'd127) >> FX_FB;
		return scaled[COL_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] frame_word_for(input logic [SLOT_W-1:0] slot,
			input logic [STEP_W-1:0] step);
		logic [POS_W-1:0]   pos;
		logic [ROM_AW-1:0]  idx;
		int unsigned        x, inten, cur, scale, r, g, b;
		if (slot >= LIT_LIMIT) return '0;
		pos = POS_W'(slot) + POS_W'(step);
		x = (pos % PHASE_MOD) * INTEN_STEP;
		inten = (x * x) / INTEN_DIV;
		cur = (inten >> 7) & 32'h1F;
		if (cur == 0) begin
			cur = 1;
			scale = inten & 32'h7F;
		end else begin
			scale = 32'h80 + (inten & 32'h7F);
		end
		idx = pos[ROM_AW-1:0];
		r = (scale * red_rom[idx]) >> 8;
		g = (scale * green_rom[idx]) >> 8;
		b = (scale * blue_rom[idx]) >> 8;
		return {r[7:0], g[7:0], b[7:0], WORD_MARK, cur[CUR_W-1:0]};
	endfunction

	task automatic add_item(input int slot, input int step, input bit drain_first, input bit steady);
		slot_item_t it;
		it.slot = SLOT_W'(slot);
		it.step = STEP_W'(step);
		it.drain_first = drain_first;
		it.steady = steady;
		slot_items.push_back(it);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!slot_valid || in_fire) begin
				if (in_gap > 0) begin
					slot_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (slot_items.size() != 0 && slot_items[0].drain_first
						&& (expected_words.size() != 0 || (slot_valid && in_fire))) begin
					slot_valid <= 1'b0;
				end else if (slot_items.size() != 0) begin
					next_item = slot_items.pop_front();
					led_slot <= next_item.slot;
					time_step <= next_item.step;
					slot_valid <= 1'b1;
					out_steady <= next_item.steady;
					if (!next_item.steady && $urandom_range(0, 99) < 10) begin
						in_gap <= $urandom_range(1, 13);
					end
				end else begin
					slot_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				word_ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else if (!out_steady && $urandom_range(0, 99) < 10) begin
				word_ready <= 1'b0;
				out_gap <= $urandom_range(0, 12);
			end else begin
				word_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else if (arst_n) begin
			in_fire <= slot_valid && slot_ready;
			if (word_valid && word_ready) begin
				if (expected_words.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("Unexpected frame word %h", frame_word);
					end
				end else begin
					wanted_word = expected_words.pop_front();
					if (frame_word !== wanted_word) begin
						mismatch_count = mismatch_count + 1;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("Frame word mismatch: expected %h, actual %h",
								wanted_word, frame_word);
						end
					end
				end
			end
			if (slot_valid && slot_ready) begin
				expected_words.push_back(frame_word_for(led_slot, time_step));
			end
		end
	end

	initial begin
		int slot, step;
		bit steady;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			red_rom[k] = sine_colour(64'(k), 64'd0);
			green_rom[k] = sine_colour(64'(k), THIRD_MANT << 8);
			blue_rom[k] = sine_colour(64'(k), THIRD_MANT << 9);
		end

		add_item(0, 0, 1'b0, 1'b0);
		add_item(0, 1, 1'b0, 1'b0);
		add_item(0, 23, 1'b0, 1'b0);
		add_item(0, 12, 1'b0, 1'b0);
		add_item(0, 256, 1'b0, 1'b0);
		add_item(LIT_LIMIT - 1, 0, 1'b0, 1'b0);
		add_item(LIT_LIMIT - 1, 16383, 1'b0, 1'b0);
		add_item(LIT_LIMIT, 0, 1'b0, 1'b0);
		add_item(LIT_LIMIT, 100, 1'b0, 1'b0);
		add_item(255, 16383, 1'b0, 1'b0);
		add_item(255, 0, 1'b0, 1'b0);
		add_item(0, 12287, 1'b0, 1'b0);
		add_item(1, 12287, 1'b0, 1'b0);
		add_item(0, 12288, 1'b0, 1'b0);
		add_item(0, 16383, 1'b0, 1'b0);
		add_item(127, 8192, 1'b1, 1'b0);
		add_item(85, 10922, 1'b0, 1'b0);
		add_item(42, 5461, 1'b0, 1'b0);
		add_item(7, 504, 1'b0, 1'b0);
		add_item(100, 411, 1'b0, 1'b0);

		for (int i = 0; i < ITEM_COUNT; i++) begin
			if ($urandom_range(0, 99) < 75) slot = $urandom_range(0, LIT_LIMIT - 1);
			else slot = $urandom_range(0, 255);
			if ($urandom_range(0, 99) < 85) step = $urandom_range(0, 12287);
			else step = $urandom_range(0, 16383);
			steady = (i >= 400 && i < 520) || (i >= ITEM_COUNT - 120);
			add_item(slot, step, (i == 300) || (i == 750), steady);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (slot_items.size() != 0 || slot_valid || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);

		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: rainbow_led_frame_word_core.f
src/rlf_pkg.sv
src/rlf_colour_rom.sv
src/rainbow_led_frame_word_core.sv
tb/sv/tb_top.sv
